FILE: rtl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared widths, codes, rule entry type and code saturation for the
// priority range quantizer.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int VALUE_W           = 48;
    localparam int CODE_W            = 32;
    localparam int DIVIDEND_W        = VALUE_W + CODE_W;
    localparam int A_HI_W            = VALUE_W - CODE_W;
    localparam int WIDE_W            = 50;
    localparam int RULE_DEPTH_DEF    = 64;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_ADDR_W        = 6;
    localparam int CFG_DATA_W        = 64;
    localparam int HELD_W            = 7;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_REVERSE = 2'd2;
    localparam logic [1:0] OP_QUANT   = 2'd3;

    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_LEFT_EN     = 3'd1;
    localparam logic [2:0] REG_LEFT_LIMIT  = 3'd2;
    localparam logic [2:0] REG_LEFT_CODE   = 3'd3;
    localparam logic [2:0] REG_RIGHT_EN    = 3'd4;
    localparam logic [2:0] REG_RIGHT_LIMIT = 3'd5;
    localparam logic [2:0] REG_RIGHT_CODE  = 3'd6;

    localparam logic signed [WIDE_W-1:0] CODE_MAX = WIDE_W'(64'sd2147483647);

    typedef struct packed {
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
        logic signed [CODE_W-1:0]  clo;
        logic signed [CODE_W-1:0]  chi;
    } rule_t;

    function automatic logic signed [CODE_W-1:0] sat_code(input logic signed [WIDE_W-1:0] c);
        logic signed [WIDE_W-1:0] r;
        begin
            r = c;
            if (c > CODE_MAX)
            begin
                r = CODE_MAX;
            end
            else if (c < -CODE_MAX)
            begin
                r = -CODE_MAX;
            end
            return r[CODE_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/prq_rule_mem.sv
// ----------------------------------------------------------------------------
// prq_rule_mem
// Rule table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prq_rule_mem #(
    parameter int DEPTH = prq_pkg::RULE_DEPTH_DEF,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  prq_pkg::rule_t  wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output prq_pkg::rule_t  rdata
);

    prq_pkg::rule_t mem [DEPTH];
    prq_pkg::rule_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/prq_div.sv
// ----------------------------------------------------------------------------
// prq_div
// Restoring divider, one quotient bit per cycle over the full dividend.
// ----------------------------------------------------------------------------
module prq_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [prq_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [prq_pkg::VALUE_W-1:0]         divisor,
    output logic                                done,
    output logic [prq_pkg::CODE_W-1:0]          quotient,
    output logic                                rem_nz
);

    localparam int CNT_W = $clog2(prq_pkg::DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(prq_pkg::DIVIDEND_W - 1);

    logic                               run_reg, run_next;
    logic                               done_reg, done_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic [prq_pkg::VALUE_W-1:0]        rem_reg, rem_next;
    logic [prq_pkg::DIVIDEND_W-1:0]     dvd_reg, dvd_next;
    logic [prq_pkg::VALUE_W-1:0]        den_reg, den_next;
    logic [prq_pkg::VALUE_W:0]          shifted;
    logic [prq_pkg::VALUE_W:0]          diff;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        shifted   = {rem_reg, dvd_reg[prq_pkg::DIVIDEND_W-1]};
        diff      = shifted - {1'b0, den_reg};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            dvd_next = dividend;
            den_next = divisor;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff[prq_pkg::VALUE_W-1:0];
                dvd_next = {dvd_reg[prq_pkg::DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[prq_pkg::VALUE_W-1:0];
                dvd_next = {dvd_reg[prq_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[prq_pkg::CODE_W-1:0];
    assign rem_nz   = (rem_reg != '0);

endmodule

FILE: rtl/priority_range_quantizer.sv
// ----------------------------------------------------------------------------
// priority_range_quantizer
// Range rule table with newest-first lookup, linear interpolation and
// open-ended fallback rules; plain truncate and round modes.
// ----------------------------------------------------------------------------
// channel    direction  handshake                 payload
// request    in         start & !busy             op, sample_*, rule_*
// result     out        done (one cycle, no stall) code, code_is_null, status,
//                                                 rules_held
// config     in         psel & penable & pwrite   paddr, pwdata (prdata back)
//
// Clear, add, plain truncate/round and null quantize: result in the next cycle.
// Reverse: swaps each pair through states S_RD_L, S_RD_R, S_WR_L and S_WR_R.
// Table quantize: rules are scanned newest first (S_S_RD, S_S_CMP), then the
// multiply states S_MUL1 and S_MUL2, the sum state S_SUM and the divider.
// Reset clears the rule count, control and config registers, not rule memory.
// The result port cannot be stalled; busy alone holds off requests.
// ----------------------------------------------------------------------------
module priority_range_quantizer #(
    parameter int RULE_DEPTH    = prq_pkg::RULE_DEPTH_DEF,
    parameter int FRACTION_BITS = prq_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             op,
    input  logic signed [prq_pkg::VALUE_W-1:0]     sample_value,
    input  logic                                   sample_is_null,
    input  logic signed [prq_pkg::VALUE_W-1:0]     rule_low_value,
    input  logic signed [prq_pkg::VALUE_W-1:0]     rule_high_value,
    input  logic signed [prq_pkg::CODE_W-1:0]      rule_low_code,
    input  logic signed [prq_pkg::CODE_W-1:0]      rule_high_code,
    output logic                                   done,
    output logic signed [prq_pkg::CODE_W-1:0]      code,
    output logic                                   code_is_null,
    output logic                                   status,
    output logic [prq_pkg::HELD_W-1:0]             rules_held,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [prq_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [prq_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [prq_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    localparam int AW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CW = $clog2(RULE_DEPTH + 1);
    localparam int VW = prq_pkg::VALUE_W;
    localparam int KW = prq_pkg::CODE_W;
    localparam int WW = prq_pkg::WIDE_W;
    localparam int HALF_SH = (FRACTION_BITS > 0) ? FRACTION_BITS - 1 : 0;
    localparam logic [VW:0] HALF = (FRACTION_BITS > 0) ? ((VW + 1)'(1) << HALF_SH) : '0;
    localparam logic [CW-1:0] DEPTH_C = CW'(RULE_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD_L  = 4'd1;
    localparam logic [3:0] S_RD_R  = 4'd2;
    localparam logic [3:0] S_WR_L  = 4'd3;
    localparam logic [3:0] S_WR_R  = 4'd4;
    localparam logic [3:0] S_S_RD  = 4'd5;
    localparam logic [3:0] S_S_CMP = 4'd6;
    localparam logic [3:0] S_MUL1  = 4'd7;
    localparam logic [3:0] S_MUL2  = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_FALL  = 4'd11;

    // configuration registers
    logic [1:0]            mode_reg;
    logic                  left_en_reg;
    logic signed [VW-1:0]  left_limit_reg;
    logic signed [KW-1:0]  left_code_reg;
    logic                  right_en_reg;
    logic signed [VW-1:0]  right_limit_reg;
    logic signed [KW-1:0]  right_code_reg;
    logic                  cfg_wr;
    logic                  clr_en;

    // control
    logic [3:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  l_reg, l_next;
    logic [CW-1:0]  r_reg, r_next;
    logic           done_reg, done_next;

    // payload
    logic signed [KW-1:0]  code_reg, code_next;
    logic                  null_reg, null_next;
    logic                  status_reg, status_next;
    logic signed [VW-1:0]  v_reg, v_next;
    prq_pkg::rule_t        ent_l_reg, ent_l_next;
    logic [VW-1:0]         a_reg, a_next;
    logic [VW-1:0]         den_reg, den_next;
    logic [KW-1:0]         m_reg, m_next;
    logic signed [KW-1:0]  clo_reg, clo_next;
    logic                  neg_reg, neg_next;
    logic                  spec_reg, spec_next;
    logic [2*KW-1:0]       p_lo_reg, p_lo_next;
    logic [VW-1:0]         p_hi_reg, p_hi_next;

    // memory and divider
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    prq_pkg::rule_t        mem_wdata, mem_q;
    logic                  div_start, div_done, div_rnz;
    logic [prq_pkg::DIVIDEND_W-1:0] div_dividend;
    logic [KW-1:0]         div_q;

    // plain modes
    logic [VW-1:0]         mag;
    logic [VW:0]           tr_mag, rd_mag;
    logic signed [WW-1:0]  trunc_w, round_w;
    logic                  accept, hit;
    logic signed [KW+1:0]  fl;

    assign accept = start && (state_reg == S_IDLE);
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        mag     = sample_value[VW-1] ? VW'(-sample_value) : VW'(sample_value);
        tr_mag  = {1'b0, mag} >> FRACTION_BITS;
        rd_mag  = ({1'b0, mag} + HALF) >> FRACTION_BITS;
        trunc_w = sample_value[VW-1] ? -$signed(WW'(tr_mag)) : $signed(WW'(tr_mag));
        round_w = (sample_value > 0) ? $signed(WW'(rd_mag)) : -$signed(WW'(rd_mag));
    end

    always_comb
    begin
        hit = (v_reg >= mem_q.lo) && (v_reg <= mem_q.hi);
        fl  = neg_reg ? ((KW + 2)'(clo_reg) - $signed((KW + 2)'(div_q))
                         - $signed((KW + 2)'(div_rnz)))
                      : ((KW + 2)'(clo_reg) + $signed((KW + 2)'(div_q)));
        // cut toward zero for negative inexact results
        if (div_rnz && fl < 0)
        begin
            fl = fl + (KW + 2)'(1);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        done_next    = 1'b0;
        code_next    = code_reg;
        null_next    = null_reg;
        status_next  = status_reg;
        v_next       = v_reg;
        ent_l_next   = ent_l_reg;
        a_next       = a_reg;
        den_next     = den_reg;
        m_next       = m_reg;
        clo_next     = clo_reg;
        neg_next     = neg_reg;
        spec_next    = spec_reg;
        p_lo_next    = p_lo_reg;
        p_hi_next    = p_hi_reg;
        mem_we       = 1'b0;
        mem_waddr    = l_reg[AW-1:0];
        mem_wdata    = mem_q;
        mem_re       = 1'b0;
        mem_raddr    = l_reg[AW-1:0];
        div_start    = 1'b0;
        div_dividend = {{prq_pkg::A_HI_W{1'b0}}, p_lo_reg} + {p_hi_reg, {KW{1'b0}}};
        clr_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    v_next      = sample_value;
                    code_next   = '0;
                    null_next   = 1'b0;
                    status_next = 1'b0;
                    unique case (op)
                        prq_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            clr_en     = 1'b1;
                            done_next  = 1'b1;
                        end
                        prq_pkg::OP_ADD:
                        begin
                            done_next = 1'b1;
                            if (count_reg >= DEPTH_C)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = count_reg[AW-1:0];
                                if (rule_high_value >= rule_low_value)
                                begin
                                    mem_wdata = '{rule_low_value, rule_high_value,
                                                  rule_low_code, rule_high_code};
                                end
                                else
                                begin
                                    mem_wdata = '{rule_high_value, rule_low_value,
                                                  rule_high_code, rule_low_code};
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        prq_pkg::OP_REVERSE:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                l_next     = '0;
                                r_next     = count_reg - 1'b1;
                                state_next = S_RD_L;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (sample_is_null)
                            begin
                                null_next = 1'b1;
                                done_next = 1'b1;
                            end
                            else if (mode_reg[0])
                            begin
                                code_next = prq_pkg::sat_code(trunc_w);
                                done_next = 1'b1;
                            end
                            else if (mode_reg[1])
                            begin
                                code_next = prq_pkg::sat_code(round_w);
                                done_next = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_FALL;
                            end
                            else
                            begin
                                l_next     = count_reg - 1'b1;
                                state_next = S_S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD_L:
            begin
                mem_re     = 1'b1;
                mem_raddr  = l_reg[AW-1:0];
                state_next = S_RD_R;
            end
            S_RD_R:
            begin
                mem_re     = 1'b1;
                mem_raddr  = r_reg[AW-1:0];
                ent_l_next = mem_q;
                state_next = S_WR_L;
            end
            S_WR_L:
            begin
                // read data holds the right-hand entry
                mem_we     = 1'b1;
                mem_waddr  = l_reg[AW-1:0];
                mem_wdata  = mem_q;
                state_next = S_WR_R;
            end
            S_WR_R:
            begin
                mem_we    = 1'b1;
                mem_waddr = r_reg[AW-1:0];
                mem_wdata = ent_l_reg;
                l_next    = l_reg + 1'b1;
                r_next    = r_reg - 1'b1;
                if ((l_reg + 1'b1) < (r_reg - 1'b1))
                begin
                    state_next = S_RD_L;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_S_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = l_reg[AW-1:0];
                state_next = S_S_CMP;
            end
            S_S_CMP:
            begin
                if (hit)
                begin
                    a_next     = VW'(v_reg - mem_q.lo);
                    den_next   = VW'(mem_q.hi - mem_q.lo);
                    neg_next   = mem_q.chi < mem_q.clo;
                    m_next     = (mem_q.chi < mem_q.clo) ? KW'(mem_q.clo - mem_q.chi)
                                                         : KW'(mem_q.chi - mem_q.clo);
                    clo_next   = mem_q.clo;
                    spec_next  = (mem_q.clo == mem_q.chi) || (mem_q.lo == mem_q.hi);
                    state_next = S_MUL1;
                end
                else if (l_reg == '0)
                begin
                    state_next = S_FALL;
                end
                else
                begin
                    l_next     = l_reg - 1'b1;
                    state_next = S_S_RD;
                end
            end
            S_MUL1:
            begin
                if (spec_reg)
                begin
                    code_next  = prq_pkg::sat_code(WW'(clo_reg));
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    p_lo_next  = a_reg[KW-1:0] * m_reg;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                p_hi_next  = VW'(a_reg[VW-1:KW] * m_reg);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    code_next  = prq_pkg::sat_code(WW'(fl));
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FALL:
            begin
                if (left_en_reg && v_reg <= left_limit_reg)
                begin
                    code_next = prq_pkg::sat_code(WW'(left_code_reg));
                end
                else if (right_en_reg && v_reg >= right_limit_reg)
                begin
                    code_next = prq_pkg::sat_code(WW'(right_code_reg));
                end
                else
                begin
                    null_next = 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            l_reg     <= '0;
            r_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            l_reg     <= l_next;
            r_reg     <= r_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        null_reg   <= null_next;
        status_reg <= status_next;
        v_reg      <= v_next;
        ent_l_reg  <= ent_l_next;
        a_reg      <= a_next;
        den_reg    <= den_next;
        m_reg      <= m_next;
        clo_reg    <= clo_next;
        neg_reg    <= neg_next;
        spec_reg   <= spec_next;
        p_lo_reg   <= p_lo_next;
        p_hi_reg   <= p_hi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= '0;
            left_en_reg     <= 1'b0;
            left_limit_reg  <= '0;
            left_code_reg   <= '0;
            right_en_reg    <= 1'b0;
            right_limit_reg <= '0;
            right_code_reg  <= '0;
        end
        else if (clr_en)
        begin
            left_en_reg  <= 1'b0;
            right_en_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                prq_pkg::REG_MODE:        mode_reg        <= pwdata[1:0];
                prq_pkg::REG_LEFT_EN:     left_en_reg     <= pwdata[0];
                prq_pkg::REG_LEFT_LIMIT:  left_limit_reg  <= pwdata[VW-1:0];
                prq_pkg::REG_LEFT_CODE:   left_code_reg   <= pwdata[KW-1:0];
                prq_pkg::REG_RIGHT_EN:    right_en_reg    <= pwdata[0];
                prq_pkg::REG_RIGHT_LIMIT: right_limit_reg <= pwdata[VW-1:0];
                prq_pkg::REG_RIGHT_CODE:  right_code_reg  <= pwdata[KW-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            prq_pkg::REG_MODE:        prdata = 64'(mode_reg);
            prq_pkg::REG_LEFT_EN:     prdata = 64'(left_en_reg);
            prq_pkg::REG_LEFT_LIMIT:  prdata = 64'(left_limit_reg);
            prq_pkg::REG_LEFT_CODE:   prdata = 64'(left_code_reg);
            prq_pkg::REG_RIGHT_EN:    prdata = 64'(right_en_reg);
            prq_pkg::REG_RIGHT_LIMIT: prdata = 64'(right_limit_reg);
            prq_pkg::REG_RIGHT_CODE:  prdata = 64'(right_code_reg);
            default:                  prdata = '0;
        endcase
    end

    prq_rule_mem #(
        .DEPTH (RULE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    prq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q),
        .rem_nz   (div_rnz)
    );

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign code         = code_reg;
    assign code_is_null = null_reg;
    assign status       = status_reg;
    assign rules_held   = prq_pkg::HELD_W'(count_reg);
    assign pready       = 1'b1;

endmodule

FILE: rtl/prq_checker.sv
// ----------------------------------------------------------------------------
// prq_checker
// Port-level checks on request acceptance and result strobes.
// ----------------------------------------------------------------------------
module prq_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               done,
    input  logic signed [prq_pkg::CODE_W-1:0]  code,
    input  logic                               code_is_null,
    input  logic                               status
);

    // an accepted request either completes at once or keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted request neither busy nor done");

    // no result without a request in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("result strobe without request");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> code == '0 && !code_is_null)
        else $error("refused add carries a code");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && code_is_null |-> code == '0 && !status)
        else $error("null result carries a code");

endmodule

bind priority_range_quantizer prq_checker u_prq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .code         (code),
    .code_is_null (code_is_null),
    .status       (status)
);
